@@ hw/rtl/ccs_pkg.sv @@
// Shared constants, codes and control structures of the channel calibration block.
package ccs_pkg;

    // Channel count and field widths.
    localparam int CHANNELS       = 8;
    localparam int CH_BITS        = 3;
    localparam int KIND_BITS      = 2;
    localparam int SAMPLE_BITS    = 10;
    localparam int GAIN_FRAC_BITS = 16;

    // Full scale of a calibrated value and the widths that follow from it.
    localparam int FULL_SCALE = 1024;
    localparam int VAL_W      = 11;
    localparam int GAIN_W     = VAL_W + GAIN_FRAC_BITS;
    localparam int PROD_W     = VAL_W + GAIN_W;
    localparam int DIV_CNT_W  = $clog2(GAIN_W);

    // Dividend of the gain division: full scale in fixed point.
    localparam logic [GAIN_W-1:0] DIV_NUM = GAIN_W'(FULL_SCALE) << GAIN_FRAC_BITS;

    // Item kinds.
    typedef enum logic [KIND_BITS-1:0] {
        KIND_CLEAR   = 2'd0,
        KIND_SAMPLE  = 2'd1,
        KIND_FINISH  = 2'd2,
        KIND_CONVERT = 2'd3
    } ccs_kind_t;

    // Result kinds.
    localparam logic RES_FINISH  = 1'b0;
    localparam logic RES_CONVERT = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FIN,
        S_CONV
    } ccs_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clear_ch;
        logic widen;
        logic div_start;
        logic div_step;
        logic mul_load;
        logic fin_write;
        logic out_load;
    } ccs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        ccs_kind_t kind;
        logic      ch_ok;
        logic      span_bad_now;
        logic      div_last;
        logic      out_free;
    } ccs_stat_t;

endpackage

@@ hw/rtl/ccs_req_if.sv @@
// Input channel: one word per item with kind, channel and sample.
interface ccs_req_if import ccs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [KIND_BITS-1:0]   kind;
    logic [CH_BITS-1:0]     channel;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output kind, output channel, output sample, input ready);
    modport sink   (input valid, input kind, input channel, input sample, output ready);
endinterface

@@ hw/rtl/ccs_rsp_if.sv @@
// Output channel: one word per result with the scaled value and flags.
interface ccs_rsp_if import ccs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [CH_BITS-1:0] result_channel;
    logic [VAL_W-1:0]   scaled_value;
    logic               clipped;
    logic               not_calibrated;

    modport source (output valid, output result_kind, output result_channel,
                    output scaled_value, output clipped, output not_calibrated,
                    input ready);
    modport sink   (input valid, input result_kind, input result_channel,
                    input scaled_value, input clipped, input not_calibrated,
                    output ready);
endinterface

@@ hw/rtl/ccs_ctrl.sv @@
// Controller state machine that sequences each item through the datapath.
module ccs_ctrl import ccs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ccs_stat_t stat,
    output ccs_cmd_t  cmd
);

    ccs_state_t state_reg;
    ccs_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!stat.ch_ok)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    case (stat.kind)
                        KIND_FINISH:  state_next = stat.span_bad_now ? S_FIN : S_DIV;
                        KIND_CONVERT: state_next = S_CONV;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN, S_CONV:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Commands for the current state.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_EXEC:
            begin
                if (stat.ch_ok)
                begin
                    case (stat.kind)
                        KIND_CLEAR:   cmd.clear_ch  = 1'b1;
                        KIND_SAMPLE:  cmd.widen     = 1'b1;
                        KIND_FINISH:  cmd.div_start = !stat.span_bad_now;
                        KIND_CONVERT: cmd.mul_load  = 1'b1;
                        default:      cmd.clear_ch  = 1'b0;
                    endcase
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_FIN:
            begin
                cmd.fin_write = stat.out_free;
                cmd.out_load  = stat.out_free;
            end
            S_CONV:
            begin
                cmd.out_load = stat.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

@@ hw/rtl/ccs_datapath.sv @@
// Datapath: per-channel calibration store, gain divider, scaling multiplier, result register.
module ccs_datapath import ccs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ccs_cmd_t               cmd,
    output ccs_stat_t              stat,
    input  logic [KIND_BITS-1:0]   in_kind,
    input  logic [CH_BITS-1:0]     in_channel,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_result_kind,
    output logic [CH_BITS-1:0]     out_result_channel,
    output logic [VAL_W-1:0]       out_scaled_value,
    output logic                   out_clipped,
    output logic                   out_not_calibrated
);

    // Latched item.
    ccs_kind_t              kind_reg;
    logic [CH_BITS-1:0]     ch_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;

    // Per-channel calibration state.
    logic [VAL_W-1:0]  low_reg   [CHANNELS];
    logic [VAL_W-1:0]  high_reg  [CHANNELS];
    logic [VAL_W-1:0]  zero_reg  [CHANNELS];
    logic [GAIN_W-1:0] gain_reg  [CHANNELS];
    logic              bad_reg   [CHANNELS];

    // Divider and multiplier registers.
    logic [VAL_W-1:0]     span_reg;
    logic [VAL_W-1:0]     acc_reg;
    logic [GAIN_W-1:0]    quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 neg_reg;

    // Result register.
    logic               out_valid_reg;
    logic               res_kind_reg;
    logic [CH_BITS-1:0] res_ch_reg;
    logic [VAL_W-1:0]   res_val_reg;
    logic               res_clip_reg;
    logic               res_bad_reg;

    logic [VAL_W-1:0]  smp_ext;
    logic [VAL_W-1:0]  cur_low;
    logic [VAL_W-1:0]  cur_high;
    logic [VAL_W-1:0]  cur_zero;
    logic              cur_bad;
    logic              smp_below;
    logic [VAL_W-1:0]  diff_mag;
    logic [VAL_W:0]    trial;
    logic              trial_ge;
    logic [PROD_W-GAIN_FRAC_BITS-1:0] mag;
    logic [VAL_W-1:0]  conv_val;
    logic              conv_clip;
    logic              out_free;

    // Channel state read at the latched channel.
    assign smp_ext   = VAL_W'(sample_reg);
    assign cur_low   = low_reg[ch_reg];
    assign cur_high  = high_reg[ch_reg];
    assign cur_zero  = zero_reg[ch_reg];
    assign cur_bad   = bad_reg[ch_reg];
    assign out_free  = !out_valid_reg || out_ready;

    // Status towards the controller.
    assign stat.kind         = kind_reg;
    assign stat.ch_ok        = ({1'b0, ch_reg} < (CH_BITS+1)'(CHANNELS));
    assign stat.span_bad_now = (cur_high <= cur_low);
    assign stat.div_last     = (div_cnt_reg == DIV_CNT_W'(GAIN_W - 1));
    assign stat.out_free     = out_free;

    // Magnitude of the difference between sample and offset.
    assign smp_below = (smp_ext < cur_zero);
    assign diff_mag  = smp_below ? (cur_zero - smp_ext) : (smp_ext - cur_zero);

    // One restoring division step.
    assign trial    = {acc_reg, quo_reg[GAIN_W-1]};
    assign trial_ge = (trial >= {1'b0, span_reg});

    // Truncation and saturation of the product.
    assign mag = prod_reg[PROD_W-1:GAIN_FRAC_BITS];
    always_comb
    begin
        conv_val  = '0;
        conv_clip = 1'b0;
        if (neg_reg)
        begin
            conv_clip = (mag != '0);
        end
        else if (mag > (PROD_W-GAIN_FRAC_BITS)'(FULL_SCALE))
        begin
            conv_val  = VAL_W'(FULL_SCALE);
            conv_clip = 1'b1;
        end
        else
        begin
            conv_val = mag[VAL_W-1:0];
        end
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= ccs_kind_t'(in_kind);
            ch_reg     <= in_channel;
            sample_reg <= in_sample;
        end
    end

    // Calibration store updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                low_reg[i]  <= VAL_W'(FULL_SCALE);
                high_reg[i] <= '0;
                zero_reg[i] <= '0;
                gain_reg[i] <= '0;
                bad_reg[i]  <= 1'b1;
            end
        end
        else
        begin
            if (cmd.clear_ch)
            begin
                low_reg[ch_reg]  <= VAL_W'(FULL_SCALE);
                high_reg[ch_reg] <= '0;
            end
            if (cmd.widen)
            begin
                if (smp_ext > cur_high)
                begin
                    high_reg[ch_reg] <= smp_ext;
                end
                if (smp_ext < cur_low)
                begin
                    low_reg[ch_reg] <= smp_ext;
                end
            end
            if (cmd.fin_write)
            begin
                zero_reg[ch_reg] <= cur_low;
                bad_reg[ch_reg]  <= stat.span_bad_now;
                gain_reg[ch_reg] <= stat.span_bad_now ? '0 : quo_reg;
            end
        end
    end

    // Gain divider, one quotient bit per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            span_reg    <= cur_high - cur_low;
            acc_reg     <= '0;
            quo_reg     <= DIV_NUM;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            acc_reg     <= trial_ge ? VAL_W'(trial - {1'b0, span_reg}) : trial[VAL_W-1:0];
            quo_reg     <= {quo_reg[GAIN_W-2:0], trial_ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // Scaling multiplier.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            prod_reg <= PROD_W'(diff_mag) * PROD_W'(gain_reg[ch_reg]);
            neg_reg  <= smp_below;
        end
    end

    // Result word valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result word payload.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_ch_reg <= ch_reg;
            if (kind_reg == KIND_CONVERT)
            begin
                res_kind_reg <= RES_CONVERT;
                res_val_reg  <= conv_val;
                res_clip_reg <= conv_clip;
                res_bad_reg  <= cur_bad;
            end
            else
            begin
                res_kind_reg <= RES_FINISH;
                res_val_reg  <= '0;
                res_clip_reg <= 1'b0;
                res_bad_reg  <= stat.span_bad_now;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_result_kind    = res_kind_reg;
    assign out_result_channel = res_ch_reg;
    assign out_scaled_value   = res_val_reg;
    assign out_clipped        = res_clip_reg;
    assign out_not_calibrated = res_bad_reg;

endmodule

@@ hw/rtl/channel_calibrate_scale_top.sv @@
// Top level of the per-channel min/max calibration and linear scaling block.
//
//   Channel | Direction | Word contents                                      | Words per item
//   req     | in        | kind, channel, sample                              | 1
//   rsp     | out       | result_kind, result_channel, scaled_value, flags   | 0 or 1
//
// Clear and calibration-sample items pass through the capture and execute steps;
// conversions add a result step. A finish item runs the restoring divider, one gain
// bit per cycle for all 27 bits, then a result step; a bad span skips the divider.
// Reset is asynchronous and restores every channel's calibration at once.
// The result register lets the next item be accepted while a word waits on rsp;
// a following item that has a result holds in its last step until rsp drains.
module channel_calibrate_scale_top import ccs_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    ccs_req_if.sink   req,
    ccs_rsp_if.source rsp
);

    ccs_cmd_t  cmd;
    ccs_stat_t stat;
    logic      in_ready;

    // Sequencing.
    ccs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    assign req.ready = in_ready;

    // Storage and arithmetic.
    ccs_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .in_kind            (req.kind),
        .in_channel         (req.channel),
        .in_sample          (req.sample),
        .out_valid          (rsp.valid),
        .out_ready          (rsp.ready),
        .out_result_kind    (rsp.result_kind),
        .out_result_channel (rsp.result_channel),
        .out_scaled_value   (rsp.scaled_value),
        .out_clipped        (rsp.clipped),
        .out_not_calibrated (rsp.not_calibrated)
    );

endmodule
